>>> hdl/dcf77_pkg.sv
package dcf77_pkg;

	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 16;
	localparam int unsigned MsW      = 16;
	localparam int unsigned CountW   = 6;
	localparam int unsigned FrameW   = 64;

	typedef enum logic [CfgIdxW-1:0] {
		REG_ACTIVE_LOW = 2'd0,
		REG_SHORT_THR  = 2'd1,
		REG_LONG_THR   = 2'd2,
		REG_MINUTE_THR = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_NONE      = 2'd0,
		ST_BAD_COUNT = 2'd1,
		ST_NORMAL    = 2'd2,
		ST_LEAP      = 2'd3
	} frame_status_t;

	localparam logic [MsW-1:0] ShortThrReset  = 16'd85;
	localparam logic [MsW-1:0] LongThrReset   = 16'd150;
	localparam logic [MsW-1:0] MinuteThrReset = 16'd1500;

	localparam logic [CountW-1:0] CountNormal = 6'd59;
	localparam logic [CountW-1:0] CountLeap   = 6'd60;
	localparam logic [CountW-1:0] CountMax    = 6'd63;

	typedef struct packed {
		logic           active_low;
		logic [MsW-1:0] short_thr;
		logic [MsW-1:0] long_thr;
		logic [MsW-1:0] minute_thr;
	} cfg_t;

	typedef struct packed {
		frame_status_t frame_status;
		logic [6:0]    minutes_bcd;
		logic [5:0]    hours_bcd;
		logic [5:0]    day_bcd;
		logic [2:0]    weekday;
		logic [4:0]    month_bcd;
		logic [7:0]    year_bcd;
		logic          leap_announce;
		logic          time_ok;
		logic          date_ok;
	} frame_fields_t;

	typedef struct packed {
		logic              last_bit_long;
		logic [CountW-1:0] second_count;
		frame_fields_t     fields;
	} result_t;

endpackage

>>> hdl/dcf77_if.sv
interface dcf77_edge_if;
	logic                     valid;
	logic                     ready;
	logic                     line_level;
	logic [dcf77_pkg::MsW-1:0] elapsed_ms;

	modport source(output valid, output line_level, output elapsed_ms, input ready);
	modport sink(input valid, input line_level, input elapsed_ms, output ready);
endinterface

interface dcf77_result_if;
	logic       valid;
	logic       ready;
	logic       last_bit_long;
	logic [5:0] second_count;
	logic [1:0] frame_status;
	logic [6:0] minutes_bcd;
	logic [5:0] hours_bcd;
	logic [5:0] day_bcd;
	logic [2:0] weekday;
	logic [4:0] month_bcd;
	logic [7:0] year_bcd;
	logic       leap_announce;
	logic       time_ok;
	logic       date_ok;

	modport source(output valid, output last_bit_long, output second_count,
		output frame_status, output minutes_bcd, output hours_bcd, output day_bcd,
		output weekday, output month_bcd, output year_bcd, output leap_announce,
		output time_ok, output date_ok, input ready);
	modport sink(input valid, input last_bit_long, input second_count,
		input frame_status, input minutes_bcd, input hours_bcd, input day_bcd,
		input weekday, input month_bcd, input year_bcd, input leap_announce,
		input time_ok, input date_ok, output ready);
endinterface

>>> hdl/dcf77_cfg_regs.sv
module dcf77_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [dcf77_pkg::CfgIdxW-1:0]      cfg_idx,
	input  logic [dcf77_pkg::CfgDataW-1:0]     cfg_wdata,
	output dcf77_pkg::cfg_t                    cfg
);

	dcf77_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_low <= 1'b0;
			cfg_q.short_thr  <= dcf77_pkg::ShortThrReset;
			cfg_q.long_thr   <= dcf77_pkg::LongThrReset;
			cfg_q.minute_thr <= dcf77_pkg::MinuteThrReset;
		end else if (cfg_we) begin
			case (dcf77_pkg::cfg_reg_t'(cfg_idx))
				dcf77_pkg::REG_ACTIVE_LOW: cfg_q.active_low <= cfg_wdata[0];
				dcf77_pkg::REG_SHORT_THR:  cfg_q.short_thr  <= cfg_wdata;
				dcf77_pkg::REG_LONG_THR:   cfg_q.long_thr   <= cfg_wdata;
				dcf77_pkg::REG_MINUTE_THR: cfg_q.minute_thr <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hdl/dcf77_frame_decode.sv
module dcf77_frame_decode (
	input  logic [dcf77_pkg::FrameW-1:0] frame,
	input  logic [dcf77_pkg::CountW-1:0] count,
	input  logic                         marker,
	input  logic [6:0]                   prev_minutes,
	input  logic [5:0]                   prev_hours,
	output dcf77_pkg::frame_fields_t     fields
);

	logic [6:0] mins;
	logic [5:0] hrs;
	logic [6:0] min_val;
	logic [6:0] prev_min_inc;
	logic [6:0] want_min;
	logic [5:0] hr_val;
	logic [5:0] prev_hr_inc;
	logic [5:0] want_hr;
	logic       start_bit;
	logic       count_good;
	logic       parity_ok;

	assign mins      = frame[27:21];
	assign hrs       = frame[34:29];
	assign start_bit = frame[20];

	// BCD to binary with no digit range check: high digit times ten plus low digit.
	assign min_val = 7'({4'd0, mins[6:4]} * 7'd10) + {3'd0, mins[3:0]};
	assign hr_val  = 6'({4'd0, hrs[5:4]} * 6'd10) + {2'd0, hrs[3:0]};

	// Both sums stay below twice their modulus, so one subtraction suffices.
	assign prev_min_inc = 7'({4'd0, prev_minutes[6:4]} * 7'd10)
		+ {3'd0, prev_minutes[3:0]} + 7'd1;
	assign want_min = (prev_min_inc >= 7'd60) ? prev_min_inc - 7'd60 : prev_min_inc;

	assign prev_hr_inc = 6'({4'd0, prev_hours[5:4]} * 6'd10) + {2'd0, prev_hours[3:0]}
		+ {5'd0, (mins == 7'd0)};
	assign want_hr = (prev_hr_inc >= 6'd24) ? prev_hr_inc - 6'd24 : prev_hr_inc;

	assign parity_ok  = ((^mins) == frame[28]) && ((^hrs) == frame[35]);
	assign count_good = (count == dcf77_pkg::CountNormal) || (count == dcf77_pkg::CountLeap);

	always_comb begin
		fields = '0;
		if (marker) begin
			if (count_good) begin
				fields.frame_status  = (count == dcf77_pkg::CountNormal) ?
					dcf77_pkg::ST_NORMAL : dcf77_pkg::ST_LEAP;
				fields.minutes_bcd   = mins;
				fields.hours_bcd     = hrs;
				fields.day_bcd       = frame[41:36];
				fields.weekday       = frame[44:42];
				fields.month_bcd     = frame[49:45];
				fields.year_bcd      = frame[57:50];
				fields.leap_announce = frame[19];
				fields.time_ok       = start_bit && parity_ok && (min_val == want_min)
					&& (hr_val == want_hr);
				fields.date_ok       = start_bit && ((^frame[57:36]) == frame[58]);
			end else begin
				fields.frame_status = dcf77_pkg::ST_BAD_COUNT;
			end
		end
	end

endmodule

>>> hdl/dcf77_pulse_frame_decoder_core.sv
// Channel   Dir  Beat carries
// edges     in   line_level, elapsed_ms (one receiver line edge)
// results   out  pulse state, second count, frame status, decoded time and date
// cfg_*     in   register write: cfg_we, cfg_idx, cfg_wdata (no read-back)
//
// One edge beat is taken every cycle unless results.ready stalls a full pipeline;
// each produces exactly one result beat. An edge passes an input register, then the
// result register after the combinational pulse classification and frame decode.
// arst_n clears the pipeline valids, the frame store, the second counter and the
// registers to their defaults; the payload registers are not reset.
// A stalled result holds the input stage; edges.ready falls only when both are full.
module dcf77_pulse_frame_decoder_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [dcf77_pkg::CfgIdxW-1:0]  cfg_idx,
	input  logic [dcf77_pkg::CfgDataW-1:0] cfg_wdata,
	dcf77_edge_if.sink                     edges,
	dcf77_result_if.source                 results
);

	dcf77_pkg::cfg_t          cfg;
	dcf77_pkg::frame_fields_t dec_fields;
	dcf77_pkg::result_t       res_s2;

	logic                          v_s1;
	logic                          line_level_s1;
	logic [dcf77_pkg::MsW-1:0]     elapsed_s1;
	logic                          v_s2;

	logic [dcf77_pkg::CountW-1:0]  count_q;
	logic [dcf77_pkg::FrameW-1:0]  frame_q;
	logic                          long_q;
	logic [6:0]                    prev_minutes_q;
	logic [5:0]                    prev_hours_q;

	logic                          adv;
	logic                          fire;
	logic                          level;
	logic                          pulse_counted;
	logic                          pulse_long;
	logic                          marker;
	logic                          decoded;
	logic [dcf77_pkg::CountW-1:0]  count_d;
	logic [dcf77_pkg::FrameW-1:0]  frame_d;
	logic                          long_d;

	dcf77_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	assign adv          = !v_s2 || results.ready;
	assign fire         = v_s1 && adv;
	assign edges.ready  = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (edges.ready) begin
			v_s1 <= edges.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (edges.ready && edges.valid) begin
			line_level_s1 <= edges.line_level;
			elapsed_s1    <= edges.elapsed_ms;
		end
	end

	// A low level after the edge ends a pulse; a high level starts one after a gap.
	assign level         = line_level_s1 ^ cfg.active_low;
	assign pulse_counted = !level && (elapsed_s1 > cfg.short_thr);
	assign pulse_long    = pulse_counted && (elapsed_s1 > cfg.long_thr);
	assign marker        = level && (elapsed_s1 > cfg.minute_thr);

	dcf77_frame_decode u_decode (
		.frame        (frame_q),
		.count        (count_q),
		.marker       (marker),
		.prev_minutes (prev_minutes_q),
		.prev_hours   (prev_hours_q),
		.fields       (dec_fields)
	);

	assign decoded = (dec_fields.frame_status == dcf77_pkg::ST_NORMAL)
		|| (dec_fields.frame_status == dcf77_pkg::ST_LEAP);

	always_comb begin
		count_d = count_q;
		frame_d = frame_q;
		long_d  = long_q;
		if (marker) begin
			count_d = '0;
			frame_d = '0;
		end else if (pulse_counted) begin
			long_d = pulse_long;
			if (pulse_long) begin
				frame_d = frame_q | ({{(dcf77_pkg::FrameW-1){1'b0}}, 1'b1} << count_q);
			end
			if (count_q != dcf77_pkg::CountMax) begin
				count_d = count_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			frame_q        <= '0;
			long_q         <= 1'b0;
			prev_minutes_q <= '0;
			prev_hours_q   <= '0;
		end else if (fire) begin
			count_q <= count_d;
			frame_q <= frame_d;
			long_q  <= long_d;
			if (decoded) begin
				prev_minutes_q <= dec_fields.minutes_bcd;
				prev_hours_q   <= dec_fields.hours_bcd;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2.last_bit_long <= long_d;
			res_s2.second_count  <= count_d;
			res_s2.fields        <= dec_fields;
		end
	end

	assign results.valid         = v_s2;
	assign results.last_bit_long = res_s2.last_bit_long;
	assign results.second_count  = res_s2.second_count;
	assign results.frame_status  = res_s2.fields.frame_status;
	assign results.minutes_bcd   = res_s2.fields.minutes_bcd;
	assign results.hours_bcd     = res_s2.fields.hours_bcd;
	assign results.day_bcd       = res_s2.fields.day_bcd;
	assign results.weekday       = res_s2.fields.weekday;
	assign results.month_bcd     = res_s2.fields.month_bcd;
	assign results.year_bcd      = res_s2.fields.year_bcd;
	assign results.leap_announce = res_s2.fields.leap_announce;
	assign results.time_ok       = res_s2.fields.time_ok;
	assign results.date_ok       = res_s2.fields.date_ok;

	// A minute marker always leaves an empty frame and a zero count behind.
	a_marker_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && marker) |=> (count_q == '0 && frame_q == '0))
		else $error("frame store not cleared at minute marker");

	// The result register reports exactly the counter value that was committed.
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (res_s2.second_count == count_q))
		else $error("reported second count differs from the counter");

	// Validity flags can only be raised by a decoded frame.
	a_ok_needs_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && (res_s2.fields.time_ok || res_s2.fields.date_ok))
		|-> (res_s2.fields.frame_status == dcf77_pkg::ST_NORMAL
		|| res_s2.fields.frame_status == dcf77_pkg::ST_LEAP))
		else $error("time or date flagged good without a decode");

	// An empty result register never holds back the input side.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s2 |-> edges.ready)
		else $error("input stalled with an empty result register");

	// The previous time moves only on a decode beat.
	a_prev_on_decode: assert property (@(posedge clk) disable iff (!arst_n)
		!(fire && decoded) |=> ($stable(prev_minutes_q) && $stable(prev_hours_q)))
		else $error("previous time changed outside a decode");

endmodule

>>> tb/dcf77_pulse_frame_decoder_core_tb.sv
module dcf77_pulse_frame_decoder_core_tb;

	localparam int StallLimit = 3000;
	localparam int RandomEdges = 650;
	localparam int SwapIdleAt = 450;
	localparam int NoIdleAt = 900;

	localparam int MsW = dcf77_pkg::MsW;
	localparam int CountW = dcf77_pkg::CountW;
	localparam int FrameW = dcf77_pkg::FrameW;
	localparam int CfgIdxW = dcf77_pkg::CfgIdxW;
	localparam int CfgDataW = dcf77_pkg::CfgDataW;

	typedef struct packed {
		logic          lvl;
		logic [MsW-1:0] ms;
		bit            typed;
		logic          lbl;
		logic [CountW-1:0] cnt;
		dcf77_pkg::frame_status_t st;
	} dir_row_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_idx;
	logic [CfgDataW-1:0] cfg_wdata;

	dcf77_edge_if   edge_bus();
	dcf77_result_if res_bus();

	dcf77_pulse_frame_decoder_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.edges     (edge_bus),
		.results   (res_bus)
	);

	// Decoder state as the block should hold it.
	logic              cfg_al = 1'b0;
	logic [MsW-1:0]    cfg_short = dcf77_pkg::ShortThrReset;
	logic [MsW-1:0]    cfg_long = dcf77_pkg::LongThrReset;
	logic [MsW-1:0]    cfg_minute = dcf77_pkg::MinuteThrReset;
	logic [CountW-1:0] sec_cnt = '0;
	logic [FrameW-1:0] frame_store = '0;
	logic              bit_long = 1'b0;
	logic [6:0]        prev_min = '0;
	logic [5:0]        prev_hr = '0;

	dcf77_pkg::result_t decoded_q[$];
	dir_row_t dir_rows[18];

	int n_err = 0;
	int n_sent = 0;
	int n_settings = 0;
	int n_normal = 0;
	int n_leap = 0;
	int n_time_good = 0;
	int n_bad = 0;
	int src_idle = 21;
	int snk_idle = 78;
	int stall_cycles = 0;
	int tod_min = 0;
	int tod_hr = 0;

	function automatic int bcd_to_int(logic [7:0] v);
		return int'(v[7:4]) * 10 + int'(v[3:0]);
	endfunction

	function automatic logic [7:0] to_bcd(int v);
		return 8'((v / 10) * 16 + v % 10);
	endfunction

	function automatic dcf77_pkg::result_t decode_edge(logic raw, logic [MsW-1:0] ms);
		dcf77_pkg::result_t r;
		logic [FrameW-1:0] f;
		int want_min;
		int want_hr;
		r = '0;
		if (raw ^ cfg_al) begin
			if (ms > cfg_minute) begin
				if (sec_cnt == dcf77_pkg::CountNormal || sec_cnt == dcf77_pkg::CountLeap) begin
					f = frame_store;
					r.fields.frame_status = (sec_cnt == dcf77_pkg::CountNormal) ?
						dcf77_pkg::ST_NORMAL : dcf77_pkg::ST_LEAP;
					r.fields.leap_announce = f[19];
					r.fields.minutes_bcd = f[27:21];
					r.fields.hours_bcd = f[34:29];
					r.fields.day_bcd = f[41:36];
					r.fields.weekday = f[44:42];
					r.fields.month_bcd = f[49:45];
					r.fields.year_bcd = f[57:50];
					if (f[20]) begin
						if ((^f[27:21]) == f[28] && (^f[34:29]) == f[35]) begin
							want_min = (bcd_to_int(8'(prev_min)) + 1) % 60;
							want_hr = (bcd_to_int(8'(prev_hr)) + (f[27:21] == '0 ? 1 : 0)) % 24;
							r.fields.time_ok = bcd_to_int(8'(f[27:21])) == want_min &&
								bcd_to_int(8'(f[34:29])) == want_hr;
						end
						r.fields.date_ok = (^f[57:36]) == f[58];
					end
					prev_min = f[27:21];
					prev_hr = f[34:29];
				end else begin
					r.fields.frame_status = dcf77_pkg::ST_BAD_COUNT;
				end
				frame_store = '0;
				sec_cnt = '0;
			end
		end else if (ms > cfg_short) begin
			bit_long = 1'b0;
			if (ms > cfg_long) begin
				frame_store[sec_cnt] = 1'b1;
				bit_long = 1'b1;
			end
			if (sec_cnt != dcf77_pkg::CountMax)
				sec_cnt = sec_cnt + 6'd1;
		end
		r.last_bit_long = bit_long;
		r.second_count = sec_cnt;
		return r;
	endfunction

	// Pulse lengths and gaps are chosen against the thresholds in force, so that
	// frames survive whatever setting is loaded where the setting allows it.
	function automatic logic [MsW-1:0] pulse_len(logic one);
		int lo0;
		int hi0;
		int lo1;
		lo0 = int'(cfg_short) + 1;
		hi0 = int'(cfg_long);
		lo1 = (cfg_long > cfg_short ? int'(cfg_long) : int'(cfg_short)) + 1;
		if (!one && hi0 >= lo0)
			return MsW'($urandom_range(hi0, lo0));
		if (lo1 <= 65535) begin
			if ($urandom_range(99) < 5)
				return MsW'($urandom_range(65535, lo1));
			return MsW'($urandom_range(lo1 + 150 > 65535 ? 65535 : lo1 + 150, lo1));
		end
		if (hi0 >= lo0)
			return MsW'($urandom_range(hi0, lo0));
		return MsW'($urandom_range(int'(cfg_short), 0));
	endfunction

	function automatic logic [MsW-1:0] gap_len();
		int hi;
		hi = cfg_minute > 1000 ? 1000 : int'(cfg_minute);
		return MsW'($urandom_range(hi, hi > 700 ? 700 : 0));
	endfunction

	function automatic logic [MsW-1:0] marker_len();
		int lo;
		if (cfg_minute == '1)
			return '1;
		lo = int'(cfg_minute) + 1;
		return MsW'($urandom_range(lo + 1200 > 65535 ? 65535 : lo + 1200, lo));
	endfunction

	function automatic void advance_tod();
		tod_min++;
		if (tod_min == 60) begin
			tod_min = 0;
			tod_hr = (tod_hr + 1) % 24;
		end
	endfunction

	function automatic logic [FrameW-1:0] build_frame();
		logic [FrameW-1:0] f;
		f = {$urandom, $urandom};
		f[20] = 1'b1;
		f[27:21] = 7'(to_bcd(tod_min));
		f[28] = ^f[27:21];
		f[34:29] = 6'(to_bcd(tod_hr));
		f[35] = ^f[34:29];
		f[41:36] = 6'(to_bcd($urandom_range(31, 1)));
		f[44:42] = 3'($urandom_range(7, 1));
		f[49:45] = 5'(to_bcd($urandom_range(12, 1)));
		f[57:50] = to_bcd($urandom_range(99, 0));
		f[58] = ^f[57:36];
		f[63:59] = '0;
		return f;
	endfunction

	function automatic void check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			n_err++;
		end
	endfunction

	task automatic send_edge(input logic raw, input logic [MsW-1:0] ms,
			input bit given_ok = 1'b0, input dcf77_pkg::result_t given = '0);
		dcf77_pkg::result_t r;
		@(negedge clk);
		while ($urandom_range(99) < src_idle) begin
			edge_bus.valid <= 1'b0;
			@(negedge clk);
		end
		edge_bus.valid <= 1'b1;
		edge_bus.line_level <= raw;
		edge_bus.elapsed_ms <= ms;
		@(posedge clk);
		while (edge_bus.ready !== 1'b1)
			@(posedge clk);
		r = decode_edge(raw, ms);
		decoded_q.push_back(given_ok ? given : r);
		case (r.fields.frame_status)
			dcf77_pkg::ST_NORMAL: n_normal++;
			dcf77_pkg::ST_LEAP: n_leap++;
			dcf77_pkg::ST_BAD_COUNT: n_bad++;
			default: ;
		endcase
		if (r.fields.time_ok)
			n_time_good++;
		n_sent++;
		if (n_sent == SwapIdleAt) begin
			src_idle = 78;
			snk_idle = 21;
		end else if (n_sent == NoIdleAt) begin
			src_idle = 0;
			snk_idle = 0;
		end
	endtask

	// Seconds 0 to n-1, each a pulse end after the previous start, then the
	// minute marker. Now and then a glitch too short to count is slipped in.
	task automatic send_frame(input int n, input logic [FrameW-1:0] f);
		for (int s = 0; s < n; s++) begin
			if (s > 0)
				send_edge(~cfg_al, gap_len());
			send_edge(cfg_al, pulse_len(s > 63 ? 1'b1 : f[s]));
			if ($urandom_range(99) < 3) begin
				send_edge(~cfg_al, gap_len());
				send_edge(cfg_al, MsW'($urandom_range(int'(cfg_short), 0)));
			end
		end
		send_edge(~cfg_al, marker_len());
	endtask

	task automatic noise_burst(input int n);
		repeat (n) begin
			if ($urandom_range(1))
				send_edge(1'($urandom), MsW'($urandom));
			else
				send_edge(1'($urandom), MsW'($urandom_range(2000, 0)));
		end
	endtask

	// Waits until every expected beat has come back and the pipeline is empty.
	task automatic settle();
		@(negedge clk);
		edge_bus.valid <= 1'b0;
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_reg(input dcf77_pkg::cfg_reg_t idx, input logic [CfgDataW-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= v;
		case (idx)
			dcf77_pkg::REG_ACTIVE_LOW: cfg_al = v[0];
			dcf77_pkg::REG_SHORT_THR: cfg_short = v;
			dcf77_pkg::REG_LONG_THR: cfg_long = v;
			dcf77_pkg::REG_MINUTE_THR: cfg_minute = v;
			default: ;
		endcase
	endtask

	task automatic apply_setting(input int k);
		logic al;
		logic [MsW-1:0] s;
		logic [MsW-1:0] l;
		logic [MsW-1:0] m;
		case (k)
			0: {al, s, l, m} = {1'b1, dcf77_pkg::ShortThrReset, dcf77_pkg::LongThrReset,
				dcf77_pkg::MinuteThrReset};
			1: {al, s, l, m} = {1'b0, 16'd0, 16'd0, 16'd0};
			2: {al, s, l, m} = {1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF};
			3: {al, s, l, m} = {1'b0, 16'd40, 16'd120, 16'd1000};
			4: {al, s, l, m} = {1'b1, 16'd10, 16'hFFFF, 16'd300};
			default: begin
				al = 1'($urandom);
				s = MsW'($urandom_range(300, 20));
				l = s + MsW'($urandom_range(300, 1));
				m = MsW'($urandom_range(3000, 400));
				if ($urandom_range(99) < 20)
					{s, l, m} = {MsW'($urandom), MsW'($urandom), MsW'($urandom)};
			end
		endcase
		settle();
		set_reg(dcf77_pkg::REG_ACTIVE_LOW, CfgDataW'(al));
		set_reg(dcf77_pkg::REG_SHORT_THR, s);
		set_reg(dcf77_pkg::REG_LONG_THR, l);
		set_reg(dcf77_pkg::REG_MINUTE_THR, m);
		@(negedge clk);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(negedge clk)
		res_bus.ready <= ($urandom_range(99) >= snk_idle);

	always @(posedge clk) begin : result_check
		dcf77_pkg::result_t want;
		if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
			if (decoded_q.size() == 0) begin
				$error("result beat arrived with no edge outstanding");
				n_err++;
			end else begin
				want = decoded_q.pop_front();
				check_field("last_bit_long", 8'(want.last_bit_long),
					8'(res_bus.last_bit_long));
				check_field("second_count", 8'(want.second_count), 8'(res_bus.second_count));
				check_field("frame_status", 8'(want.fields.frame_status),
					8'(res_bus.frame_status));
				check_field("minutes_bcd", 8'(want.fields.minutes_bcd),
					8'(res_bus.minutes_bcd));
				check_field("hours_bcd", 8'(want.fields.hours_bcd), 8'(res_bus.hours_bcd));
				check_field("day_bcd", 8'(want.fields.day_bcd), 8'(res_bus.day_bcd));
				check_field("weekday", 8'(want.fields.weekday), 8'(res_bus.weekday));
				check_field("month_bcd", 8'(want.fields.month_bcd), 8'(res_bus.month_bcd));
				check_field("year_bcd", want.fields.year_bcd, res_bus.year_bcd);
				check_field("leap_announce", 8'(want.fields.leap_announce),
					8'(res_bus.leap_announce));
				check_field("time_ok", 8'(want.fields.time_ok), 8'(res_bus.time_ok));
				check_field("date_ok", 8'(want.fields.date_ok), 8'(res_bus.date_ok));
			end
		end
	end

	always @(posedge clk) begin
		if ((edge_bus.valid === 1'b1 && edge_bus.ready === 1'b1) ||
				(res_bus.valid === 1'b1 && res_bus.ready === 1'b1)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles == StallLimit) begin
				$display("FAIL dcf77_pulse_frame_decoder_core");
				$finish;
			end
		end
	end

	initial begin
		int rand_start;
		int k;
		int kind;
		int fault;
		logic [FrameW-1:0] f;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		edge_bus.valid = 1'b0;
		edge_bus.line_level = 1'b0;
		edge_bus.elapsed_ms = '0;
		res_bus.ready = 1'b0;

		// Default thresholds: 85 ms short, 150 ms long, 1500 ms minute.
		dir_rows = '{
			'{1'b1, 16'hFFFF, 1'b1, 1'b0, 6'd0, dcf77_pkg::ST_BAD_COUNT},
			'{1'b0, 16'd0,    1'b1, 1'b0, 6'd0, dcf77_pkg::ST_NONE},
			'{1'b0, 16'd85,   1'b1, 1'b0, 6'd0, dcf77_pkg::ST_NONE},
			'{1'b0, 16'd86,   1'b1, 1'b0, 6'd1, dcf77_pkg::ST_NONE},
			'{1'b1, 16'd1500, 1'b1, 1'b0, 6'd1, dcf77_pkg::ST_NONE},
			'{1'b0, 16'd150,  1'b1, 1'b0, 6'd2, dcf77_pkg::ST_NONE},
			'{1'b0, 16'd151,  1'b1, 1'b1, 6'd3, dcf77_pkg::ST_NONE},
			'{1'b0, 16'd100,  1'b1, 1'b0, 6'd4, dcf77_pkg::ST_NONE},
			'{1'b0, 16'hFFFF, 1'b1, 1'b1, 6'd5, dcf77_pkg::ST_NONE},
			'{1'b0, 16'd50,   1'b1, 1'b1, 6'd5, dcf77_pkg::ST_NONE},
			'{1'b1, 16'd0,    1'b1, 1'b1, 6'd5, dcf77_pkg::ST_NONE},
			'{1'b1, 16'd1501, 1'b1, 1'b1, 6'd0, dcf77_pkg::ST_BAD_COUNT},
			'{1'b0, 16'd200,  1'b0, 1'b0, 6'd0, dcf77_pkg::ST_NONE},
			'{1'b1, 16'd950,  1'b0, 1'b0, 6'd0, dcf77_pkg::ST_NONE},
			'{1'b0, 16'd120,  1'b0, 1'b0, 6'd0, dcf77_pkg::ST_NONE},
			'{1'b1, 16'h8000, 1'b0, 1'b0, 6'd0, dcf77_pkg::ST_NONE},
			'{1'b0, 16'h5555, 1'b0, 1'b0, 6'd0, dcf77_pkg::ST_NONE},
			'{1'b1, 16'hAAAA, 1'b0, 1'b0, 6'd0, dcf77_pkg::ST_NONE}
		};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			send_edge(dir_rows[i].lvl, dir_rows[i].ms, dir_rows[i].typed,
				dcf77_pkg::result_t'({dir_rows[i].lbl, dir_rows[i].cnt, dir_rows[i].st,
				38'd0}));
		end

		// Consecutive frames from midnight, a leap frame, the hour wrap after a
		// jump, then a run of long pulses that pins the second counter at 63.
		advance_tod();
		send_frame(59, build_frame());
		advance_tod();
		send_frame(60, build_frame());
		tod_min = 59;
		tod_hr = 23;
		send_frame(59, build_frame());
		advance_tod();
		send_frame(59, build_frame());
		send_frame(70, '1);

		rand_start = n_sent;
		k = 0;
		while (n_sent < rand_start + RandomEdges) begin
			apply_setting(k);
			send_edge(~cfg_al, marker_len());
			if (k != 2) begin
				repeat ($urandom_range(2, 1)) begin
					kind = $urandom_range(99);
					if (kind < 65) begin
						if ($urandom_range(99) < 10) begin
							tod_min = $urandom_range(59, 0);
							tod_hr = $urandom_range(23, 0);
						end else begin
							advance_tod();
						end
						f = build_frame();
						fault = $urandom_range(99);
						if (fault < 3)
							f[28] = ~f[28];
						else if (fault < 6)
							f[35] = ~f[35];
						else if (fault < 9)
							f[58] = ~f[58];
						else if (fault < 13)
							f[20] = 1'b0;
						send_frame(($urandom_range(99) < 15) ? 60 : 59, f);
					end else if (kind < 75) begin
						send_frame($urandom_range(60, 59), {$urandom, $urandom});
					end else if (kind < 87) begin
						send_frame($urandom_range(70, 0), {$urandom, $urandom});
					end else begin
						noise_burst($urandom_range(20, 5));
					end
				end
			end
			noise_burst($urandom_range(12, 3));
			k++;
		end

		settle();
		$display("Sent %0d edge beats under %0d register settings after reset defaults.",
			n_sent, n_settings);
		$display("Frame ends: %0d normal, %0d leap (%0d with time good), %0d bad counts.",
			n_normal, n_leap, n_time_good, n_bad);
		if (n_err == 0)
			$display("PASS dcf77_pulse_frame_decoder_core");
		else
			$display("FAIL dcf77_pulse_frame_decoder_core");
		$finish;
	end

endmodule

>>> filelist.f
hdl/dcf77_pkg.sv
hdl/dcf77_if.sv
hdl/dcf77_cfg_regs.sv
hdl/dcf77_frame_decode.sv
hdl/dcf77_pulse_frame_decoder_core.sv
tb/dcf77_pulse_frame_decoder_core_tb.sv
